FILE: rtl/sma_pkg.sv
package sma_pkg;

	localparam int FEAT_W = 8;
	localparam int NUM_FEAT = 4;
	localparam int NUM_PAIR = 10;
	localparam int PIDX_W = $clog2(NUM_PAIR);
	localparam int COLS_W = 3;
	localparam int ENTRY_W = 41;
	localparam int QUEUE_DEPTH = 2;

	localparam int DEF_MAX_SAMPLES = 65536;
	localparam int DEF_MAX_COLUMNS = 4;

	localparam longint ENTRY_MAX = (64'sd1 <<< (ENTRY_W - 1)) - 64'sd1;
	localparam longint ENTRY_MIN = -(64'sd1 <<< (ENTRY_W - 1));

	// Register indexes, taken from the word address bit of paddr.
	localparam logic REG_NUM_COLUMNS = 1'b0;

	// Upper-triangle pairs in row-major order.
	localparam logic [1:0] PAIR_ROW [NUM_PAIR] = '{
		2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
	};
	localparam logic [1:0] PAIR_COL [NUM_PAIR] = '{
		2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
	};

	typedef enum logic [2:0] {
		B_IDLE,
		B_PICK,
		B_LDB,
		B_MUL,
		B_DLD,
		B_DIV,
		B_FIX,
		B_EMIT
	} back_state_t;

endpackage

FILE: rtl/sma_if.sv
interface sma_sample_if;
	logic                       valid;
	logic                       ready;
	logic [sma_pkg::FEAT_W-1:0] feature_0;
	logic [sma_pkg::FEAT_W-1:0] feature_1;
	logic [sma_pkg::FEAT_W-1:0] feature_2;
	logic [sma_pkg::FEAT_W-1:0] feature_3;
	logic                       last_sample;

	modport source (output valid, feature_0, feature_1, feature_2, feature_3, last_sample,
		input ready);
	modport sink (input valid, feature_0, feature_1, feature_2, feature_3, last_sample,
		output ready);
endinterface

interface sma_entry_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         row_index;
	logic [1:0]                         col_index;
	logic signed [sma_pkg::ENTRY_W-1:0] entry_value;
	logic                               last_entry;

	modport source (output valid, row_index, col_index, entry_value, last_entry,
		input ready);
	modport sink (input valid, row_index, col_index, entry_value, last_entry,
		output ready);
endinterface

FILE: rtl/sma_front.sv
module sma_front #(
	parameter int MAX_SAMPLES = sma_pkg::DEF_MAX_SAMPLES,
	parameter int MAX_COLUMNS = sma_pkg::DEF_MAX_COLUMNS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	sma_sample_if.sink              sample,
	input  logic [sma_pkg::COLS_W-1:0] cols_cfg,
	input  logic                    push_ready,
	output logic                    push,
	output logic [sma_pkg::NUM_FEAT-1:0][$clog2(MAX_SAMPLES+1)+7:0]  push_csum,
	output logic [sma_pkg::NUM_PAIR-1:0][$clog2(MAX_SAMPLES+1)+15:0] push_psum,
	output logic [$clog2(MAX_SAMPLES+1)-1:0] push_cnt,
	output logic [sma_pkg::COLS_W-1:0] push_cols
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int CSUM_W = CNT_W + 8;
	localparam int PSUM_W = CNT_W + 16;
	localparam int EFF_MAX = (MAX_COLUMNS < sma_pkg::NUM_FEAT) ? MAX_COLUMNS
		: sma_pkg::NUM_FEAT;

	logic [sma_pkg::NUM_FEAT-1:0][CSUM_W-1:0] csum_q;
	logic [sma_pkg::NUM_PAIR-1:0][PSUM_W-1:0] psum_q;
	logic [CNT_W-1:0]                         cnt_q;

	logic [sma_pkg::FEAT_W-1:0] f [sma_pkg::NUM_FEAT];
	logic [2*sma_pkg::FEAT_W-1:0] pp [sma_pkg::NUM_PAIR];
	logic accept;
	logic room;

	assign f[0] = sample.feature_0;
	assign f[1] = sample.feature_1;
	assign f[2] = sample.feature_2;
	assign f[3] = sample.feature_3;

	assign sample.ready = push_ready;
	assign accept = sample.valid && sample.ready;
	assign push = accept && sample.last_sample;
	assign room = cnt_q < CNT_W'(MAX_SAMPLES);

	always_comb begin
		for (int i = 0; i < sma_pkg::NUM_FEAT; i++) begin
			push_csum[i] = room ? csum_q[i] + CSUM_W'(f[i]) : csum_q[i];
		end
		for (int p = 0; p < sma_pkg::NUM_PAIR; p++) begin
			pp[p] = f[sma_pkg::PAIR_ROW[p]] * f[sma_pkg::PAIR_COL[p]];
			push_psum[p] = room ? psum_q[p] + PSUM_W'(pp[p]) : psum_q[p];
		end
		push_cnt = room ? cnt_q + CNT_W'(1) : cnt_q;
		if (cols_cfg == '0) begin
			push_cols = sma_pkg::COLS_W'(1);
		end else if (cols_cfg > sma_pkg::COLS_W'(EFF_MAX)) begin
			push_cols = sma_pkg::COLS_W'(EFF_MAX);
		end else begin
			push_cols = cols_cfg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q <= '0;
			psum_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (sample.last_sample) begin
				csum_q <= '0;
				psum_q <= '0;
				cnt_q  <= '0;
			end else begin
				csum_q <= push_csum;
				psum_q <= push_psum;
				cnt_q  <= push_cnt;
			end
		end
	end

endmodule

FILE: rtl/sma_queue.sv
module sma_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH = sma_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              push_ready,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/sma_back.sv
module sma_back #(
	parameter int MAX_SAMPLES = sma_pkg::DEF_MAX_SAMPLES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  logic [sma_pkg::NUM_FEAT-1:0][$clog2(MAX_SAMPLES+1)+7:0]  head_csum,
	input  logic [sma_pkg::NUM_PAIR-1:0][$clog2(MAX_SAMPLES+1)+15:0] head_psum,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0] head_cnt,
	input  logic [sma_pkg::COLS_W-1:0] head_cols,
	output logic                 pop,
	sma_entry_if.source          entry
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int CSUM_W = CNT_W + 8;
	localparam int PSUM_W = CNT_W + 16;
	localparam int PROD_W = 2 * CSUM_W;
	localparam int DW = PROD_W + 8;
	localparam int V_W = DW + 2;
	localparam int STEP_W = $clog2(DW + 1);

	localparam logic signed [V_W-1:0] SAT_MAX = V_W'(sma_pkg::ENTRY_MAX);
	localparam logic signed [V_W-1:0] SAT_MIN = V_W'(sma_pkg::ENTRY_MIN);

	sma_pkg::back_state_t state_q, state_d;

	logic [sma_pkg::PIDX_W-1:0] idx_q;
	logic [PROD_W-1:0]          mcand_q;
	logic [CSUM_W-1:0]          mplier_q;
	logic [PROD_W-1:0]          prod_q;
	logic [PSUM_W-1:0]          psum_q;
	logic [DW-1:0]              num_q;
	logic [CNT_W:0]             rem_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [V_W-1:0]      v_q;

	logic                         out_valid_q;
	logic [1:0]                   out_row_q;
	logic [1:0]                   out_col_q;
	logic signed [sma_pkg::ENTRY_W-1:0] out_val_q;
	logic                         out_last_q;

	logic [1:0] row;
	logic [1:0] col;
	logic skip;
	logic is_last;
	logic out_free;
	logic load_out;
	logic [CNT_W:0] rem_sh;
	logic           qbit;
	logic signed [V_W-1:0] v_adj;
	logic signed [V_W-1:0] v_sat;

	assign row = sma_pkg::PAIR_ROW[idx_q];
	assign col = sma_pkg::PAIR_COL[idx_q];
	assign skip = sma_pkg::COLS_W'(col) >= head_cols;
	assign is_last = (sma_pkg::COLS_W'(row) + sma_pkg::COLS_W'(1) == head_cols)
		&& (sma_pkg::COLS_W'(col) + sma_pkg::COLS_W'(1) == head_cols);
	assign out_free = !out_valid_q || entry.ready;

	// One restoring division step: bring down the next dividend bit.
	assign rem_sh = {rem_q[CNT_W-1:0], num_q[DW-1]};
	assign qbit = rem_sh >= {1'b0, head_cnt};

	// Truncation toward zero, then clamp to the entry range.
	always_comb begin
		if (head_cnt == '0) begin
			v_adj = '0;
		end else if (rem_q != '0 && v_q > 0) begin
			v_adj = v_q - V_W'(1);
		end else begin
			v_adj = v_q;
		end
		if (v_adj > SAT_MAX) begin
			v_sat = SAT_MAX;
		end else if (v_adj < SAT_MIN) begin
			v_sat = SAT_MIN;
		end else begin
			v_sat = v_adj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sma_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			sma_pkg::B_IDLE: begin
				if (head_valid) begin
					state_d = sma_pkg::B_PICK;
				end
			end
			sma_pkg::B_PICK: begin
				if (!skip) begin
					state_d = sma_pkg::B_LDB;
				end
			end
			sma_pkg::B_LDB: state_d = sma_pkg::B_MUL;
			sma_pkg::B_MUL: begin
				if (step_q == STEP_W'(CSUM_W - 1)) begin
					state_d = sma_pkg::B_DLD;
				end
			end
			sma_pkg::B_DLD: state_d = sma_pkg::B_DIV;
			sma_pkg::B_DIV: begin
				if (step_q == STEP_W'(DW - 1)) begin
					state_d = sma_pkg::B_FIX;
				end
			end
			sma_pkg::B_FIX: state_d = sma_pkg::B_EMIT;
			sma_pkg::B_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					if (is_last) begin
						pop = 1'b1;
						state_d = sma_pkg::B_IDLE;
					end else begin
						state_d = sma_pkg::B_PICK;
					end
				end
			end
			default: state_d = sma_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sma_pkg::B_IDLE: begin
				idx_q <= '0;
			end
			sma_pkg::B_PICK: begin
				if (skip) begin
					idx_q <= idx_q + sma_pkg::PIDX_W'(1);
				end else begin
					mcand_q <= PROD_W'(head_csum[row]);
					psum_q  <= head_psum[idx_q];
					prod_q  <= '0;
				end
			end
			sma_pkg::B_LDB: begin
				mplier_q <= head_csum[col];
				step_q   <= '0;
			end
			sma_pkg::B_MUL: begin
				if (mplier_q[0]) begin
					prod_q <= prod_q + mcand_q;
				end
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[CSUM_W-1:1]};
				step_q   <= step_q + STEP_W'(1);
			end
			sma_pkg::B_DLD: begin
				num_q  <= {prod_q, 8'd0};
				rem_q  <= '0;
				step_q <= '0;
			end
			sma_pkg::B_DIV: begin
				rem_q  <= qbit ? rem_sh - {1'b0, head_cnt} : rem_sh;
				num_q  <= {num_q[DW-2:0], qbit};
				step_q <= step_q + STEP_W'(1);
			end
			sma_pkg::B_FIX: begin
				v_q <= $signed({{(V_W-PSUM_W-8){1'b0}}, psum_q, 8'd0})
					- $signed({2'b00, num_q});
			end
			sma_pkg::B_EMIT: begin
				if (out_free && !is_last) begin
					idx_q <= idx_q + sma_pkg::PIDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row_q  <= row;
			out_col_q  <= col;
			out_val_q  <= sma_pkg::ENTRY_W'(v_sat);
			out_last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (entry.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign entry.valid = out_valid_q;
	assign entry.row_index = out_row_q;
	assign entry.col_index = out_col_q;
	assign entry.entry_value = out_val_q;
	assign entry.last_entry = out_last_q;

endmodule

FILE: rtl/scatter_matrix_accumulator.sv
// Channel   Modport   Transaction
// sample    sink      four unsigned feature bytes and the last_sample mark
// entry     source    one upper-triangle entry: row, column, value, last mark
// APB       slave     num_columns at byte address 0, write and read back
//
// The sample channel takes one transaction per cycle. A sample marked last moves a
// snapshot of all sums into a two-entry queue; sample.ready drops only while it is full.
// Each matrix entry passes through the back end's shift-add multiplier and bit-serial
// divider, skipped pairs are stepped over one by one, and the back end returns to idle
// between matrices; a stalled entry channel holds only the back end.
// Reset clears all sums, the count, the queue and the output valid flag.
module scatter_matrix_accumulator #(
	parameter int MAX_SAMPLES = sma_pkg::DEF_MAX_SAMPLES,
	parameter int MAX_COLUMNS = sma_pkg::DEF_MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sma_sample_if.sink  sample,
	sma_entry_if.source entry
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int CSUM_W = CNT_W + 8;
	localparam int PSUM_W = CNT_W + 16;
	localparam int DATA_W = sma_pkg::NUM_FEAT * CSUM_W + sma_pkg::NUM_PAIR * PSUM_W
		+ CNT_W + sma_pkg::COLS_W;

	// Raw register value; the front end clamps it when a set is closed.
	logic [sma_pkg::COLS_W-1:0] cols_q;

	logic push;
	logic push_ready;
	logic pop;
	logic head_valid;
	logic [DATA_W-1:0] push_data;
	logic [DATA_W-1:0] head_data;

	logic [sma_pkg::NUM_FEAT-1:0][CSUM_W-1:0] f_csum, h_csum;
	logic [sma_pkg::NUM_PAIR-1:0][PSUM_W-1:0] f_psum, h_psum;
	logic [CNT_W-1:0]                         f_cnt, h_cnt;
	logic [sma_pkg::COLS_W-1:0]               f_cols, h_cols;

	// The register is decoded on the word address bit alone.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == sma_pkg::REG_NUM_COLUMNS)
		? {{(32 - sma_pkg::COLS_W){1'b0}}, cols_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= sma_pkg::COLS_W'(4);
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == sma_pkg::REG_NUM_COLUMNS) begin
			cols_q <= pwdata[sma_pkg::COLS_W-1:0];
		end
	end

	// Front end: accumulates samples until the count is full and closes a set on its last one.
	sma_front #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cols_cfg  (cols_q),
		.push_ready(push_ready),
		.push      (push),
		.push_csum (f_csum),
		.push_psum (f_psum),
		.push_cnt  (f_cnt),
		.push_cols (f_cols)
	);

	assign push_data = {f_cols, f_cnt, f_psum, f_csum};

	// Snapshot queue between the two halves.
	sma_queue #(
		.DATA_W(DATA_W),
		.DEPTH (sma_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	assign {h_cols, h_cnt, h_psum, h_csum} = head_data;

	// Back end: works through the pairs of the oldest snapshot and emits the unskipped ones.
	sma_back #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_csum (h_csum),
		.head_psum (h_psum),
		.head_cnt  (h_cnt),
		.head_cols (h_cols),
		.pop       (pop),
		.entry     (entry)
	);

endmodule

FILE: rtl/sma_checker.sv
module sma_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              e_valid,
	input logic                              e_ready,
	input logic [1:0]                        e_row,
	input logic [1:0]                        e_col,
	input logic signed [sma_pkg::ENTRY_W-1:0] e_value,
	input logic                              e_last
);

	// Entries only come from the upper triangle.
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid |-> e_col >= e_row)
		else $error("entry below the diagonal");

	// The closing entry of a matrix is always a diagonal one.
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid && e_last |-> e_row == e_col)
		else $error("last entry off the diagonal");

	// The bottom right corner can only close a matrix.
	a_corner_last: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid && e_row == 2'd3 && e_col == 2'd3 |-> e_last)
		else $error("corner entry not marked last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		e_valid && !e_ready |=> e_valid && $stable(e_value) && $stable(e_row)
			&& $stable(e_col) && $stable(e_last))
		else $error("stalled entry changed");

endmodule

bind scatter_matrix_accumulator sma_checker u_sma_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.e_valid(entry.valid),
	.e_ready(entry.ready),
	.e_row  (entry.row_index),
	.e_col  (entry.col_index),
	.e_value(entry.entry_value),
	.e_last (entry.last_entry)
);

FILE: tb/sma_checker.sv
// Watches the sample, entry and register channels of the scatter matrix block.
// It keeps its own copy of the sums and the column setting, works out every
// matrix entry that a marked sample causes, and compares each entry transaction
// with the oldest one still owed.
module sma_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	sma_sample_if       sample,
	sma_entry_if        entry,
	output int          mismatches,
	output int          entries_owed
);

	localparam logic [sma_pkg::COLS_W-1:0] NUM_COLUMNS_RESET = 3'd4;

	typedef struct {
		logic [1:0]                         row;
		logic [1:0]                         col;
		logic signed [sma_pkg::ENTRY_W-1:0] value;
		logic                               last;
	} matrix_entry_t;

	matrix_entry_t              scatter_entries [$];
	logic [23:0]                col_sum [sma_pkg::NUM_FEAT];
	logic [31:0]                prod_sum [sma_pkg::NUM_PAIR];
	logic [16:0]                n_samples;
	logic [sma_pkg::COLS_W-1:0] num_columns;
	int                         err_count = 0;

	// 256*(n*Sjk - Sj*Sk)/n, truncated toward zero and clipped to the entry range.
	function automatic logic signed [sma_pkg::ENTRY_W-1:0] centered_entry(input longint n,
		input longint sj, input longint sk, input longint sjk);
		longint prod;
		longint quo;
		longint rem;
		longint frac;
		longint frac_rem;
		longint v;
		if (n == 0) begin
			return '0;
		end
		prod = sj * sk;
		quo = prod / n;
		rem = prod % n;
		frac = (rem <<< 8) / n;
		frac_rem = (rem <<< 8) % n;
		v = (sjk - quo) * 256 - frac;
		if (frac_rem != 0 && v > 0) begin
			v = v - 1;
		end
		if (v > sma_pkg::ENTRY_MAX) begin
			v = sma_pkg::ENTRY_MAX;
		end
		if (v < sma_pkg::ENTRY_MIN) begin
			v = sma_pkg::ENTRY_MIN;
		end
		return v[sma_pkg::ENTRY_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		matrix_entry_t want;
		logic [7:0]    f [sma_pkg::NUM_FEAT];
		int            cols;
		if (!arst_n) begin
			foreach (col_sum[i]) col_sum[i] = '0;
			foreach (prod_sum[i]) prod_sum[i] = '0;
			n_samples = '0;
			num_columns = NUM_COLUMNS_RESET;
			scatter_entries.delete();
			entries_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready
				&& paddr[2] == sma_pkg::REG_NUM_COLUMNS) begin
				num_columns = pwdata[sma_pkg::COLS_W-1:0];
			end

			if (entry.valid && entry.ready) begin
				if (scatter_entries.size() == 0) begin
					err_count++;
					$display({"%0t: entry with none owed, expected nothing, ",
						"actual (%0d,%0d) %0d last %0b"},
						$time, entry.row_index, entry.col_index, entry.entry_value,
						entry.last_entry);
				end else begin
					want = scatter_entries.pop_front();
					if (entry.row_index !== want.row || entry.col_index !== want.col ||
						entry.entry_value !== want.value || entry.last_entry !== want.last) begin
						err_count++;
						$display({"%0t: entry mismatch, expected (%0d,%0d) %0d last %0b, ",
							"actual (%0d,%0d) %0d last %0b"},
							$time, want.row, want.col, want.value, want.last,
							entry.row_index, entry.col_index, entry.entry_value,
							entry.last_entry);
					end
				end
			end

			if (sample.valid && sample.ready) begin
				f[0] = sample.feature_0;
				f[1] = sample.feature_1;
				f[2] = sample.feature_2;
				f[3] = sample.feature_3;
				// A full count freezes the sums; the sample still counts for its last mark.
				if (n_samples < sma_pkg::DEF_MAX_SAMPLES) begin
					for (int c = 0; c < sma_pkg::NUM_FEAT; c++) begin
						col_sum[c] = col_sum[c] + f[c];
					end
					for (int p = 0; p < sma_pkg::NUM_PAIR; p++) begin
						prod_sum[p] = prod_sum[p]
							+ f[sma_pkg::PAIR_ROW[p]] * f[sma_pkg::PAIR_COL[p]];
					end
					n_samples = n_samples + 1'b1;
				end
				if (sample.last_sample) begin
					cols = num_columns;
					if (cols < 1) cols = 1;
					if (cols > sma_pkg::DEF_MAX_COLUMNS) cols = sma_pkg::DEF_MAX_COLUMNS;
					if (cols > sma_pkg::NUM_FEAT) cols = sma_pkg::NUM_FEAT;
					for (int p = 0; p < sma_pkg::NUM_PAIR; p++) begin
						if (sma_pkg::PAIR_COL[p] < cols) begin
							want.row = sma_pkg::PAIR_ROW[p];
							want.col = sma_pkg::PAIR_COL[p];
							want.value = centered_entry(n_samples,
								col_sum[sma_pkg::PAIR_ROW[p]],
								col_sum[sma_pkg::PAIR_COL[p]], prod_sum[p]);
							want.last = 1'b0;
							scatter_entries.insert(scatter_entries.size(), want);
						end
					end
					scatter_entries[scatter_entries.size() - 1].last = 1'b1;
					foreach (col_sum[i]) col_sum[i] = '0;
					foreach (prod_sum[i]) prod_sum[i] = '0;
					n_samples = '0;
				end
			end

			entries_owed <= scatter_entries.size();
			mismatches <= err_count;
		end
	end

endmodule

FILE: tb/tb.sv
// Top of the scatter matrix testbench. It makes the clock and the single reset,
// drives samples and register writes, shapes the handshakes on both channels,
// and gives the verdict from the failure count that the checker hands back.
module tb;

	// Settling time that follows the tail of a ten-entry matrix once nothing
	// is owed any more.
	localparam int SETTLE_CYCLES = 200;
	// Length of the long receiver hold-off that fills the snapshot queue.
	localparam int LONG_HOLD = 3000;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 56;

	// How the features of one random set are drawn.
	typedef enum int {
		FS_UNIFORM,
		FS_NARROW,
		FS_EXTREME,
		FS_CONSTANT,
		FS_FLIP
	} feature_style_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int entries_owed;
	int cycle_count = 0;

	// Idle rates in percent per cycle. The receiver's copy is written with a
	// nonblocking assignment because another process reads it at the same edge.
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_requests = 0;

	// Column settings of the random phases: both extremes, the middle values,
	// zero (which acts as one) and the values beyond four (which act as four).
	int cfg_plan [RANDOM_PHASES] = '{1, 4, 2, 7, 3, 0, 5, 6};

	sma_sample_if sample_ch ();
	sma_entry_if  entry_ch ();

	scatter_matrix_accumulator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample_ch),
		.entry   (entry_ch)
	);

	sma_tb_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.sample       (sample_ch),
		.entry        (entry_ch),
		.mismatches   (mismatches),
		.entries_owed (entries_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs: a correct run finishes far earlier.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Entry receiver. Outside a hold-off it drops ready at the current idle rate.
	// A hold-off is requested by the stimulus process and counted here, so the
	// sender keeps offering samples while the snapshot queue fills up.
	initial begin
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left = 0;
		entry_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				entry_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				entry_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Offers one sample, idling first at the sender's rate, and returns at the
	// edge where the transaction is taken. Valid gets one assignment per edge.
	task automatic send_sample(input logic [7:0] f0, input logic [7:0] f1,
		input logic [7:0] f2, input logic [7:0] f3, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.feature_0 <= f0;
		sample_ch.feature_1 <= f1;
		sample_ch.feature_2 <= f2;
		sample_ch.feature_3 <= f3;
		sample_ch.last_sample <= last;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	// APB write of num_columns: a setup cycle, then an access cycle that ends at
	// the edge where pready is seen high. The upper data bits are junk on purpose.
	task automatic write_num_columns(input logic [sma_pkg::COLS_W-1:0] cols);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sma_pkg::REG_NUM_COLUMNS, 2'b00};
		pwdata <= ($urandom() & 32'hFFFF_FFF8) | 32'(cols);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stops offering samples and waits until every owed entry has come back,
	// then waits out SETTLE_CYCLES. The first edge lets the
	// checker's count catch up with a sample taken at the current edge.
	task automatic drain_entries();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (entries_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int snd_pct, input int rcv_pct);
		sender_idle_pct = snd_pct;
		receiver_idle_pct <= rcv_pct;
	endtask

	function automatic logic [7:0] pick_feature(input feature_style_t style,
		input logic [7:0] base);
		logic [7:0] v;
		case (style)
			FS_UNIFORM: begin
				v = 8'($urandom_range(255));
			end
			FS_NARROW: begin
				v = base + 8'($urandom_range(6)) - 8'd3;
			end
			FS_EXTREME: begin
				v = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			FS_CONSTANT: begin
				v = base;
			end
			default: begin
				v = base ^ (8'h01 << $urandom_range(7));
			end
		endcase
		return v;
	endfunction

	// Random data sets, each closed by a last mark. Most sets are short, since
	// every set costs a whole matrix of slow divisions; a few run longer. Sets
	// of a single sample exercise back-to-back last marks. The final set of a
	// phase is cut so that the phase sends exactly its share of samples.
	task automatic run_random_sets(input int n_items);
		int             sent;
		int             roll;
		int             set_len;
		feature_style_t style;
		logic [7:0]     base [sma_pkg::NUM_FEAT];
		logic [7:0]     f [sma_pkg::NUM_FEAT];
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(99);
			if (roll < 15) begin
				set_len = 1;
			end else if (roll < 80) begin
				set_len = $urandom_range(6, 2);
			end else if (roll < 95) begin
				set_len = $urandom_range(16, 7);
			end else begin
				set_len = $urandom_range(40, 17);
			end
			if (set_len > n_items - sent) begin
				set_len = n_items - sent;
			end
			style = feature_style_t'($urandom_range(4));
			for (int c = 0; c < sma_pkg::NUM_FEAT; c++) begin
				base[c] = 8'($urandom_range(255));
			end
			for (int i = 0; i < set_len; i++) begin
				for (int c = 0; c < sma_pkg::NUM_FEAT; c++) begin
					f[c] = pick_feature(style, base[c]);
				end
				send_sample(f[0], f[1], f[2], f[3], i == set_len - 1);
			end
			sent += set_len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.feature_0 = '0;
		sample_ch.feature_1 = '0;
		sample_ch.feature_2 = '0;
		sample_ch.feature_3 = '0;
		sample_ch.last_sample = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sets at the reset setting of four columns, with a slow receiver.
		set_idling(12, 87);
		// One sample only: every centered entry is zero, at both extremes.
		send_sample(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		send_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		// Zero and full scale: the largest spread two samples can have.
		send_sample(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		// Opposed columns give negative entries; the odd third sample leaves a
		// remainder so truncation toward zero matters on both signs.
		send_sample(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
		send_sample(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
		send_sample(8'h01, 8'h02, 8'h03, 8'h04, 1'b1);
		// Alternating bit patterns, so every feature bit toggles early.
		send_sample(8'hAA, 8'h55, 8'h0F, 8'hF0, 1'b0);
		send_sample(8'h55, 8'hAA, 8'hF0, 8'h0F, 1'b0);
		send_sample(8'h80, 8'h7F, 8'h01, 8'hFE, 1'b1);
		drain_entries();

		// A column count of zero acts as one: a single entry per set.
		write_num_columns(3'd0);
		send_sample(8'd10, 8'd200, 8'd33, 8'd7, 1'b0);
		send_sample(8'd250, 8'd3, 8'd99, 8'd180, 1'b1);
		drain_entries();

		// The largest register value acts as four columns.
		write_num_columns(3'd7);
		send_sample(8'd17, 8'd240, 8'd128, 8'd127, 1'b0);
		send_sample(8'd230, 8'd9, 8'd64, 8'd191, 1'b1);
		drain_entries();

		// Random phases: slow receiver first, then slow sender, then no idling.
		// The very first phase also opens with a long receiver hold-off.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 3) begin
				set_idling(12, 87);
			end else if (ph < 6) begin
				set_idling(87, 12);
			end else begin
				set_idling(0, 0);
			end
			write_num_columns(3'(cfg_plan[ph]));
			if (ph == 0) begin
				hold_requests <= hold_requests + 1;
			end
			run_random_sets(ITEMS_PER_PHASE);
			drain_entries();
		end

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
